// ----- sv/mpqs_pkg.sv -----
// ----------------------------------------------------------------------------
// mpqs_pkg: shared types and constants for the max priority queue scan core
// Word formats, status codes, sequencer states and the slot encoding.
// ----------------------------------------------------------------------------
package mpqs_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam int PRIO_W         = 15;
  localparam int SLOT_W         = 16;

  // Reserved slot value for an empty slot; a stored priority never has bit 15.
  localparam logic [SLOT_W-1:0] EMPTY_MARK = {SLOT_W{1'b1}};

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_SKIP
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [PRIO_W-1:0] job_priority;
  } cmd_word_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] out_priority;
  } result_word_t;

endpackage

// ----- sv/max_priority_queue_scan_core.sv -----
// ----------------------------------------------------------------------------
// max_priority_queue_scan_core: max priority queue over a ring of slots
// Enqueue appends at the rear; dequeue scans the live span for the largest
// priority, removes it and moves the front past leading holes.
// ----------------------------------------------------------------------------
//  channel | signals             | handshake
//  --------+---------------------+---------------------------------------
//  command | start, busy, cmd    | word taken when start && !busy
//  result  | done, result        | one word per command, done for 1 cycle
//
//  Enqueue and dequeue on an empty ring: result in the cycle after the command,
//  busy stays low. Dequeue otherwise: one slot read per cycle on the single
//  RAM read port over the live span (N slots), then the DRAIN and DECIDE
//  states settle the winner and register the result; busy then covers the
//  front skip, one slot a cycle. Reset is synchronous; slots outside the live
//  span are never scanned, so no clearing pass is needed. Results cannot be
//  stalled.
// ----------------------------------------------------------------------------
module max_priority_queue_scan_core #(
  parameter int RING_DEPTH = mpqs_pkg::RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  mpqs_pkg::cmd_word_t    cmd,
  output logic                   done,
  output mpqs_pkg::result_word_t result
);

  localparam int AW = $clog2(RING_DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  mpqs_pkg::state_t state, state_next;

  logic [AW-1:0] head, tail, scan_addr, skip_addr, rd_addr_q;
  logic          rd_pend;

  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [mpqs_pkg::SLOT_W-1:0] wr_data, rd_data;

  logic                        best_found;
  logic [AW-1:0]               best_addr;
  logic [mpqs_pkg::PRIO_W-1:0] best_val;

  logic accept, is_full, is_empty, rd_hole, head_last;

  assign accept    = start && !busy;
  assign is_full   = (ring_next(tail) == head);
  assign is_empty  = (head == tail);
  assign rd_hole   = (rd_data == mpqs_pkg::EMPTY_MARK);
  assign head_last = (ring_next(head) == tail);
  assign busy      = (state != mpqs_pkg::S_IDLE);

  mpqs_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .W     (mpqs_pkg::SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mpqs_best #(
    .AW (AW)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .clear      (state == mpqs_pkg::S_IDLE),
    .in_valid   (rd_pend && (state == mpqs_pkg::S_SCAN || state == mpqs_pkg::S_DRAIN)),
    .in_addr    (rd_addr_q),
    .in_data    (rd_data),
    .best_found (best_found),
    .best_addr  (best_addr),
    .best_val   (best_val)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpqs_pkg::S_IDLE: begin
        if (accept && cmd.op == mpqs_pkg::OP_DEQ && !is_empty) begin
          state_next = mpqs_pkg::S_SCAN;
        end
      end
      mpqs_pkg::S_SCAN: begin
        if (scan_addr == tail) begin
          state_next = mpqs_pkg::S_DRAIN;
        end
      end
      mpqs_pkg::S_DRAIN: begin
        state_next = mpqs_pkg::S_DECIDE;
      end
      mpqs_pkg::S_DECIDE: begin
        state_next = best_found ? mpqs_pkg::S_SKIP : mpqs_pkg::S_IDLE;
      end
      mpqs_pkg::S_SKIP: begin
        if (rd_pend && (!rd_hole || head_last)) begin
          state_next = mpqs_pkg::S_IDLE;
        end
      end
      default: state_next = mpqs_pkg::S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    wr_en   = 1'b0;
    wr_addr = ring_next(tail);
    wr_data = {1'b0, cmd.job_priority};
    unique case (state)
      mpqs_pkg::S_IDLE: begin
        wr_en = accept && (cmd.op == mpqs_pkg::OP_ENQ) && !is_full;
      end
      mpqs_pkg::S_SCAN: begin
        rd_en = 1'b1;
      end
      mpqs_pkg::S_DRAIN: begin
        rd_en = 1'b0;
      end
      mpqs_pkg::S_DECIDE: begin
        wr_en   = best_found;
        wr_addr = best_addr;
        wr_data = mpqs_pkg::EMPTY_MARK;
      end
      mpqs_pkg::S_SKIP: begin
        rd_en   = 1'b1;
        rd_addr = skip_addr;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mpqs_pkg::S_IDLE;
      head    <= '0;
      tail    <= '0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      unique case (state)
        mpqs_pkg::S_IDLE: begin
          // enqueue and empty dequeue answer at once
          done <= accept && (cmd.op == mpqs_pkg::OP_ENQ || is_empty);
          if (accept && cmd.op == mpqs_pkg::OP_ENQ && !is_full) begin
            tail <= ring_next(tail);
          end
        end
        mpqs_pkg::S_DECIDE: begin
          done <= 1'b1;
        end
        mpqs_pkg::S_SKIP: begin
          done <= 1'b0;
          if (rd_pend && rd_hole) begin
            if (head_last) begin
              head <= '0;
              tail <= '0;
            end else begin
              head <= ring_next(head);
            end
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  // payload and address registers
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    unique case (state)
      mpqs_pkg::S_IDLE: begin
        scan_addr <= ring_next(head);
        if (cmd.op == mpqs_pkg::OP_ENQ) begin
          result.status <= is_full ? mpqs_pkg::ST_FULL : mpqs_pkg::ST_ENQ;
        end else begin
          result.status <= mpqs_pkg::ST_EMPTY;
        end
        result.out_priority <= '0;
      end
      mpqs_pkg::S_SCAN: begin
        scan_addr <= ring_next(scan_addr);
      end
      mpqs_pkg::S_DRAIN: begin
        skip_addr <= ring_next(head);
      end
      mpqs_pkg::S_DECIDE: begin
        if (best_found) begin
          result.status       <= mpqs_pkg::ST_DEQ;
          result.out_priority <= best_val;
        end else begin
          result.status       <= mpqs_pkg::ST_EMPTY;
          result.out_priority <= '0;
        end
      end
      mpqs_pkg::S_SKIP: begin
        skip_addr <= ring_next(skip_addr);
      end
      default: skip_addr <= skip_addr;
    endcase
  end

endmodule

// ----- sv/mpqs_ram.sv -----
// ----------------------------------------------------------------------------
// mpqs_ram: slot store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mpqs_ram #(
  parameter int DEPTH = mpqs_pkg::RING_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int W     = mpqs_pkg::SLOT_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/mpqs_best.sv -----
// ----------------------------------------------------------------------------
// mpqs_best: shared compare unit
// Keeps the largest live slot seen so far; earliest slot wins on ties.
// ----------------------------------------------------------------------------
module mpqs_best #(
  parameter int AW = $clog2(mpqs_pkg::RING_DEPTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        in_valid,
  input  logic [AW-1:0]               in_addr,
  input  logic [mpqs_pkg::SLOT_W-1:0] in_data,
  output logic                        best_found,
  output logic [AW-1:0]               best_addr,
  output logic [mpqs_pkg::PRIO_W-1:0] best_val
);

  logic take;

  // strict greater keeps the earlier slot on a tie
  assign take = in_valid && (in_data != mpqs_pkg::EMPTY_MARK) &&
                (!best_found || (in_data[mpqs_pkg::PRIO_W-1:0] > best_val));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_found <= 1'b0;
    end else if (take) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_addr <= in_addr;
      best_val  <= in_data[mpqs_pkg::PRIO_W-1:0];
    end
  end

endmodule

// ----- sv/mpqs_checker.sv -----
// ----------------------------------------------------------------------------
// mpqs_port_checks: port-level checks for the max priority queue scan core
// Watches command and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module mpqs_port_checks (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input mpqs_pkg::cmd_word_t    cmd,
  input logic                   done,
  input mpqs_pkg::result_word_t result
);

  // enqueue answers in the next cycle without going busy
  a_enq_prompt: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == mpqs_pkg::OP_ENQ) |=>
      (done && !busy &&
       (result.status == mpqs_pkg::ST_ENQ || result.status == mpqs_pkg::ST_FULL)))
    else $error("enqueue word not answered in next cycle");

  // dequeue either scans or reports empty at once
  a_deq_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == mpqs_pkg::OP_DEQ) |=>
      (busy || (done && result.status == mpqs_pkg::ST_EMPTY)))
    else $error("dequeue word neither scanned nor reported empty");

  a_prio_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != mpqs_pkg::ST_DEQ) |-> (result.out_priority == '0))
    else $error("nonzero priority on a word without a dequeue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("core not quiet after reset");

endmodule

bind max_priority_queue_scan_core mpqs_port_checks u_mpqs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
